@@ hdl/sab_pkg.sv @@
// types and constants shared by the suffix automaton builder
// depends on nothing; used by sab_ctrl, sab_datapath and the top level
package sab_pkg;

    // capacity and alphabet, fixed by the port widths
    localparam int MAX_LEN    = 512;
    localparam int MAX_STATES = 1024;
    localparam int ALPHABET   = 64;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_ZERO_RES,
        OP_FULL_RES,
        OP_NEW,
        OP_CLR_START,
        OP_ROWCLR,
        OP_WALK_RD,
        OP_WALK_SET,
        OP_TAKE_Q,
        OP_Q_RD,
        OP_LINK_V_Q,
        OP_CLONE1,
        OP_CLONE2,
        OP_CLONE3,
        OP_CP_RD,
        OP_CP_WR,
        OP_REDIR,
        OP_APP_DONE,
        OP_FIN_START,
        OP_TERM_CLR,
        OP_FP_MARK,
        OP_FP_NEXT,
        OP_REP_RD,
        OP_REP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_INIT_SWEEP,
        S_IDLE,
        S_DISPATCH,
        S_NEW_CLR,
        S_WALK,
        S_WALK_EV,
        S_QRD,
        S_QEV,
        S_CL2,
        S_CL3,
        S_CPRD,
        S_CPWR,
        S_RDR,
        S_RDR_EV,
        S_APP_DONE,
        S_TCLR,
        S_FP,
        S_FP_NEXT,
        S_CCLR,
        S_REP_RD,
        S_REP_OUT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  sym_ok;
        logic  full;
        logic  p_neg;
        logic  p_pos;
        logic  tr_zero;
        logic  tr_eq_q;
        logic  len_match;
        logic  sweep_last;
        logic  k_last;
    } dp_stat_t;

endpackage

@@ hdl/suffix_automaton_builder.sv @@
// top level of the suffix automaton builder
// depends on sab_pkg, sab_ctrl and sab_datapath
//
// channel   signals                          transfer
// command   start, busy, func, symbol,       start high and busy low at a clock edge
//           query_state
// result    done, state_id .. full_res       done high for one cycle, always taken
//
// append: clears the new state's row, then walks the suffix links; when the walk meets a
//   transition it reads the target state, and a clone copies that row and redirects the
//   transitions that pointed at the target, stopping at the root or at another target
// finish: clears the terminal marks of all states, then marks the suffix link chain
// clear: clears the root row; read: reads the queried state; rejected append: zero or full result
// after reset the root row is cleared with busy high
// results cannot be stalled
module suffix_automaton_builder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [5:0]         symbol,
    input  logic [9:0]         query_state,
    output logic               done,
    output logic [9:0]         state_id,
    output logic signed [10:0] suffix_link,
    output logic [9:0]         length,
    output logic [9:0]         transition,
    output logic               is_terminal,
    output logic               clone_made,
    output logic [9:0]         clone_id,
    output logic [10:0]        state_count,
    output logic               full_res
);

    sab_pkg::dp_cmd_t  cmd;
    sab_pkg::dp_stat_t stat;

    sab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    sab_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .symbol      (symbol),
        .query_state (query_state),
        .done        (done),
        .state_id    (state_id),
        .suffix_link (suffix_link),
        .length      (length),
        .transition  (transition),
        .is_terminal (is_terminal),
        .clone_made  (clone_made),
        .clone_id    (clone_id),
        .state_count (state_count),
        .full_res    (full_res)
    );

endmodule

@@ hdl/sab_ctrl.sv @@
// controller state machine of the suffix automaton builder
// depends on sab_pkg; drives sab_datapath through command and status structs
module sab_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sab_pkg::dp_stat_t stat,
    output sab_pkg::dp_cmd_t  cmd
);

    sab_pkg::ctl_state_t state_reg;
    sab_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sab_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sab_pkg::OP_NONE;
        busy       = 1'b1;
        case (state_reg)
            sab_pkg::S_INIT:
            begin
                cmd.op     = sab_pkg::OP_CLR_START;
                state_next = sab_pkg::S_INIT_SWEEP;
            end
            sab_pkg::S_INIT_SWEEP:
            begin
                cmd.op = sab_pkg::OP_ROWCLR;
                if (stat.sweep_last)
                begin
                    state_next = sab_pkg::S_IDLE;
                end
            end
            sab_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op     = sab_pkg::OP_LATCH;
                    state_next = sab_pkg::S_DISPATCH;
                end
            end
            sab_pkg::S_DISPATCH:
            begin
                case (stat.func)
                    sab_pkg::FUNC_APPEND:
                    begin
                        if (!stat.sym_ok)
                        begin
                            cmd.op     = sab_pkg::OP_ZERO_RES;
                            state_next = sab_pkg::S_IDLE;
                        end
                        else if (stat.full)
                        begin
                            cmd.op     = sab_pkg::OP_FULL_RES;
                            state_next = sab_pkg::S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = sab_pkg::OP_NEW;
                            state_next = sab_pkg::S_NEW_CLR;
                        end
                    end
                    sab_pkg::FUNC_FINISH:
                    begin
                        cmd.op     = sab_pkg::OP_FIN_START;
                        state_next = sab_pkg::S_TCLR;
                    end
                    sab_pkg::FUNC_CLEAR:
                    begin
                        cmd.op     = sab_pkg::OP_CLR_START;
                        state_next = sab_pkg::S_CCLR;
                    end
                    default:
                    begin
                        cmd.op     = sab_pkg::OP_REP_RD;
                        state_next = sab_pkg::S_REP_OUT;
                    end
                endcase
            end
            sab_pkg::S_NEW_CLR:
            begin
                cmd.op = sab_pkg::OP_ROWCLR;
                if (stat.sweep_last)
                begin
                    state_next = sab_pkg::S_WALK;
                end
            end
            sab_pkg::S_WALK:
            begin
                if (stat.p_neg)
                begin
                    cmd.op     = sab_pkg::OP_APP_DONE;
                    state_next = sab_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_WALK_RD;
                    state_next = sab_pkg::S_WALK_EV;
                end
            end
            sab_pkg::S_WALK_EV:
            begin
                if (stat.tr_zero)
                begin
                    cmd.op     = sab_pkg::OP_WALK_SET;
                    state_next = sab_pkg::S_WALK;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_TAKE_Q;
                    state_next = sab_pkg::S_QRD;
                end
            end
            sab_pkg::S_QRD:
            begin
                cmd.op     = sab_pkg::OP_Q_RD;
                state_next = sab_pkg::S_QEV;
            end
            sab_pkg::S_QEV:
            begin
                if (stat.len_match)
                begin
                    cmd.op     = sab_pkg::OP_LINK_V_Q;
                    state_next = sab_pkg::S_APP_DONE;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_CLONE1;
                    state_next = sab_pkg::S_CL2;
                end
            end
            sab_pkg::S_CL2:
            begin
                cmd.op     = sab_pkg::OP_CLONE2;
                state_next = sab_pkg::S_CL3;
            end
            sab_pkg::S_CL3:
            begin
                cmd.op     = sab_pkg::OP_CLONE3;
                state_next = sab_pkg::S_CPRD;
            end
            sab_pkg::S_CPRD:
            begin
                cmd.op     = sab_pkg::OP_CP_RD;
                state_next = sab_pkg::S_CPWR;
            end
            sab_pkg::S_CPWR:
            begin
                cmd.op     = sab_pkg::OP_CP_WR;
                state_next = stat.sweep_last ? sab_pkg::S_RDR : sab_pkg::S_CPRD;
            end
            sab_pkg::S_RDR:
            begin
                if (stat.p_neg)
                begin
                    cmd.op     = sab_pkg::OP_APP_DONE;
                    state_next = sab_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_WALK_RD;
                    state_next = sab_pkg::S_RDR_EV;
                end
            end
            sab_pkg::S_RDR_EV:
            begin
                if (stat.tr_eq_q)
                begin
                    cmd.op     = sab_pkg::OP_REDIR;
                    state_next = sab_pkg::S_RDR;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_APP_DONE;
                    state_next = sab_pkg::S_IDLE;
                end
            end
            sab_pkg::S_APP_DONE:
            begin
                cmd.op     = sab_pkg::OP_APP_DONE;
                state_next = sab_pkg::S_IDLE;
            end
            sab_pkg::S_TCLR:
            begin
                cmd.op = sab_pkg::OP_TERM_CLR;
                if (stat.k_last)
                begin
                    state_next = sab_pkg::S_FP;
                end
            end
            sab_pkg::S_FP:
            begin
                if (stat.p_pos)
                begin
                    cmd.op     = sab_pkg::OP_FP_MARK;
                    state_next = sab_pkg::S_FP_NEXT;
                end
                else
                begin
                    cmd.op     = sab_pkg::OP_REP_RD;
                    state_next = sab_pkg::S_REP_OUT;
                end
            end
            sab_pkg::S_FP_NEXT:
            begin
                cmd.op     = sab_pkg::OP_FP_NEXT;
                state_next = sab_pkg::S_FP;
            end
            sab_pkg::S_CCLR:
            begin
                cmd.op = sab_pkg::OP_ROWCLR;
                if (stat.sweep_last)
                begin
                    state_next = sab_pkg::S_REP_RD;
                end
            end
            sab_pkg::S_REP_RD:
            begin
                cmd.op     = sab_pkg::OP_REP_RD;
                state_next = sab_pkg::S_REP_OUT;
            end
            sab_pkg::S_REP_OUT:
            begin
                cmd.op     = sab_pkg::OP_REP_OUT;
                state_next = sab_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sab_pkg::S_INIT;
            end
        endcase
    end

endmodule

@@ hdl/sab_datapath.sv @@
// datapath of the suffix automaton builder: state memories and working registers
// depends on sab_pkg; commanded by sab_ctrl
module sab_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sab_pkg::dp_cmd_t    cmd,
    output sab_pkg::dp_stat_t   stat,
    input  logic [1:0]          func,
    input  logic [5:0]          symbol,
    input  logic [9:0]          query_state,
    output logic                done,
    output logic [9:0]          state_id,
    output logic signed [10:0]  suffix_link,
    output logic [9:0]          length,
    output logic [9:0]          transition,
    output logic                is_terminal,
    output logic                clone_made,
    output logic [9:0]          clone_id,
    output logic [10:0]         state_count,
    output logic                full_res
);

    localparam int MAX_LEN    = sab_pkg::MAX_LEN;
    localparam int MAX_STATES = sab_pkg::MAX_STATES;
    localparam int ALPHABET   = sab_pkg::ALPHABET;
    localparam int SW     = $clog2(MAX_STATES);
    localparam int CW     = $clog2(MAX_STATES + 1);
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int AW     = $clog2(ALPHABET);
    localparam int TDEPTH = MAX_STATES * ALPHABET;
    localparam int TAW    = $clog2(TDEPTH);

    typedef logic [SW-1:0]        sidx_t;
    typedef logic signed [SW:0]   link_t;

    // state memories
    sidx_t         trans_mem [TDEPTH];
    link_t         link_mem  [MAX_STATES];
    logic [LW-1:0] len_mem   [MAX_STATES];
    logic          term_mem  [MAX_STATES];

    logic           t_we, t_re, l_we, l_re, n_we, n_re, m_we, m_re;
    logic [TAW-1:0] t_wa, t_ra;
    sidx_t          t_wd, l_wa, l_ra, n_wa, n_ra, m_wa, m_ra;
    link_t          l_wd;
    logic [LW-1:0]  n_wd;
    logic           m_wd;

    sidx_t         tr_rd;
    link_t         link_rd;
    logic [LW-1:0] len_rd;
    logic          term_rd;

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            trans_mem[t_wa] <= t_wd;
        end
        if (t_re)
        begin
            tr_rd <= trans_mem[t_ra];
        end
        if (l_we)
        begin
            link_mem[l_wa] <= l_wd;
        end
        if (l_re)
        begin
            link_rd <= link_mem[l_ra];
        end
        if (n_we)
        begin
            len_mem[n_wa] <= n_wd;
        end
        if (n_re)
        begin
            len_rd <= len_mem[n_ra];
        end
        if (m_we)
        begin
            term_mem[m_wa] <= m_wd;
        end
        if (m_re)
        begin
            term_rd <= term_mem[m_ra];
        end
    end

    function automatic logic [TAW-1:0] tidx(input sidx_t s, input logic [AW-1:0] c);
        tidx = TAW'(32'(s) * ALPHABET + 32'(c));
    endfunction

    // working registers
    sab_pkg::func_t func_reg, func_next;
    logic [5:0]     sym_reg, sym_next;
    logic [9:0]     qs_reg, qs_next;
    sidx_t          last_reg, last_next;
    logic [LW-1:0]  last_len_reg, last_len_next;
    logic [CW-1:0]  count_reg, count_next;
    sidx_t          v_reg, v_next;
    logic [LW-1:0]  lenv_reg, lenv_next;
    link_t          vlink_reg, vlink_next;
    link_t          p_reg, p_next;
    sidx_t          q_reg, q_next;
    logic [LW-1:0]  lenp_reg, lenp_next;
    sidx_t          clone_reg, clone_next;
    logic           made_reg, made_next;
    sidx_t          row_reg, row_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  kidx_reg, kidx_next;

    logic           done_reg, done_next;
    logic [9:0]     o_id_reg, o_id_next;
    logic [10:0]    o_link_reg, o_link_next;
    logic [9:0]     o_len_reg, o_len_next;
    logic [9:0]     o_tr_reg, o_tr_next;
    logic           o_term_reg, o_term_next;
    logic           o_made_reg, o_made_next;
    logic [9:0]     o_clone_reg, o_clone_next;
    logic [10:0]    o_count_reg, o_count_next;
    logic           o_full_reg, o_full_next;

    logic [15:0]    sym_w;
    logic [AW-1:0]  c_sel;
    sidx_t          p_idx;
    sidx_t          rep_s;
    logic           is_read;
    logic           qs_ok;

    assign sym_w   = 16'(sym_reg);
    assign c_sel   = sym_w[AW-1:0];
    assign p_idx   = p_reg[SW-1:0];
    assign is_read = (func_reg == sab_pkg::FUNC_READ);
    assign rep_s   = is_read ? SW'(qs_reg) : last_reg;
    assign qs_ok   = 32'(qs_reg) < 32'(count_reg);

    always_comb
    begin
        stat.func       = func_reg;
        stat.sym_ok     = sym_w < 16'(ALPHABET);
        stat.full       = ((CW+1)'(count_reg) + (CW+1)'(2) > (CW+1)'(MAX_STATES))
                          || (32'(last_len_reg) >= MAX_LEN);
        stat.p_neg      = p_reg < 0;
        stat.p_pos      = p_reg > 0;
        stat.tr_zero    = tr_rd == '0;
        stat.tr_eq_q    = tr_rd == q_reg;
        stat.len_match  = (lenp_reg + LW'(1)) == len_rd;
        stat.sweep_last = idx_reg == AW'(ALPHABET - 1);
        stat.k_last     = kidx_reg == (count_reg - CW'(1));
    end

    always_comb
    begin
        func_next     = func_reg;
        sym_next      = sym_reg;
        qs_next       = qs_reg;
        last_next     = last_reg;
        last_len_next = last_len_reg;
        count_next    = count_reg;
        v_next        = v_reg;
        lenv_next     = lenv_reg;
        vlink_next    = vlink_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        lenp_next     = lenp_reg;
        clone_next    = clone_reg;
        made_next     = made_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        kidx_next     = kidx_reg;
        done_next     = 1'b0;
        o_id_next     = o_id_reg;
        o_link_next   = o_link_reg;
        o_len_next    = o_len_reg;
        o_tr_next     = o_tr_reg;
        o_term_next   = o_term_reg;
        o_made_next   = o_made_reg;
        o_clone_next  = o_clone_reg;
        o_count_next  = o_count_reg;
        o_full_next   = o_full_reg;

        t_we = 1'b0; t_wa = '0; t_wd = '0; t_re = 1'b0; t_ra = '0;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_re = 1'b0; l_ra = '0;
        n_we = 1'b0; n_wa = '0; n_wd = '0; n_re = 1'b0; n_ra = '0;
        m_we = 1'b0; m_wa = '0; m_wd = 1'b0; m_re = 1'b0; m_ra = '0;

        case (cmd.op)
            sab_pkg::OP_LATCH:
            begin
                func_next = sab_pkg::func_t'(func);
                sym_next  = symbol;
                qs_next   = query_state;
            end
            sab_pkg::OP_ZERO_RES, sab_pkg::OP_FULL_RES:
            begin
                done_next    = 1'b1;
                o_id_next    = '0;
                o_link_next  = '0;
                o_len_next   = '0;
                o_tr_next    = '0;
                o_term_next  = 1'b0;
                o_made_next  = 1'b0;
                o_clone_next = '0;
                o_count_next = 11'(count_reg);
                o_full_next  = (cmd.op == sab_pkg::OP_FULL_RES);
            end
            sab_pkg::OP_NEW:
            begin
                v_next     = SW'(count_reg);
                count_next = count_reg + CW'(1);
                lenv_next  = last_len_reg + LW'(1);
                vlink_next = '0;
                clone_next = '0;
                made_next  = 1'b0;
                p_next     = link_t'({1'b0, last_reg});
                row_next   = SW'(count_reg);
                idx_next   = '0;
                l_we = 1'b1; l_wa = SW'(count_reg); l_wd = '0;
                n_we = 1'b1; n_wa = SW'(count_reg); n_wd = last_len_reg + LW'(1);
                m_we = 1'b1; m_wa = SW'(count_reg); m_wd = 1'b0;
            end
            sab_pkg::OP_CLR_START:
            begin
                row_next      = '0;
                idx_next      = '0;
                last_next     = '0;
                last_len_next = '0;
                count_next    = CW'(1);
                l_we = 1'b1; l_wa = '0; l_wd = '1;
                n_we = 1'b1; n_wa = '0; n_wd = '0;
                m_we = 1'b1; m_wa = '0; m_wd = 1'b0;
            end
            sab_pkg::OP_ROWCLR:
            begin
                t_we     = 1'b1;
                t_wa     = tidx(row_reg, idx_reg);
                t_wd     = '0;
                idx_next = idx_reg + AW'(1);
            end
            sab_pkg::OP_WALK_RD:
            begin
                t_re = 1'b1; t_ra = tidx(p_idx, c_sel);
                l_re = 1'b1; l_ra = p_idx;
                n_re = 1'b1; n_ra = p_idx;
            end
            sab_pkg::OP_WALK_SET:
            begin
                t_we   = 1'b1;
                t_wa   = tidx(p_idx, c_sel);
                t_wd   = v_reg;
                p_next = link_rd;
            end
            sab_pkg::OP_TAKE_Q:
            begin
                q_next    = tr_rd;
                lenp_next = len_rd;
            end
            sab_pkg::OP_Q_RD:
            begin
                l_re = 1'b1; l_ra = q_reg;
                n_re = 1'b1; n_ra = q_reg;
            end
            sab_pkg::OP_LINK_V_Q:
            begin
                vlink_next = link_t'({1'b0, q_reg});
                l_we = 1'b1; l_wa = v_reg; l_wd = link_t'({1'b0, q_reg});
            end
            sab_pkg::OP_CLONE1:
            begin
                clone_next = SW'(count_reg);
                count_next = count_reg + CW'(1);
                made_next  = 1'b1;
                l_we = 1'b1; l_wa = SW'(count_reg); l_wd = link_rd;
                n_we = 1'b1; n_wa = SW'(count_reg); n_wd = lenp_reg + LW'(1);
                m_we = 1'b1; m_wa = SW'(count_reg); m_wd = 1'b0;
            end
            sab_pkg::OP_CLONE2:
            begin
                vlink_next = link_t'({1'b0, clone_reg});
                l_we = 1'b1; l_wa = v_reg; l_wd = link_t'({1'b0, clone_reg});
            end
            sab_pkg::OP_CLONE3:
            begin
                idx_next = '0;
                l_we = 1'b1; l_wa = q_reg; l_wd = link_t'({1'b0, clone_reg});
            end
            sab_pkg::OP_CP_RD:
            begin
                t_re = 1'b1; t_ra = tidx(q_reg, idx_reg);
            end
            sab_pkg::OP_CP_WR:
            begin
                t_we     = 1'b1;
                t_wa     = tidx(clone_reg, idx_reg);
                t_wd     = tr_rd;
                idx_next = idx_reg + AW'(1);
            end
            sab_pkg::OP_REDIR:
            begin
                t_we   = 1'b1;
                t_wa   = tidx(p_idx, c_sel);
                t_wd   = clone_reg;
                p_next = link_rd;
            end
            sab_pkg::OP_APP_DONE:
            begin
                last_next     = v_reg;
                last_len_next = lenv_reg;
                done_next     = 1'b1;
                o_id_next     = 10'(v_reg);
                o_link_next   = 11'(32'(vlink_reg));
                o_len_next    = 10'(lenv_reg);
                o_tr_next     = '0;
                o_term_next   = 1'b0;
                o_made_next   = made_reg;
                o_clone_next  = 10'(clone_reg);
                o_count_next  = 11'(count_reg);
                o_full_next   = 1'b0;
            end
            sab_pkg::OP_FIN_START:
            begin
                kidx_next = '0;
                p_next    = link_t'({1'b0, last_reg});
            end
            sab_pkg::OP_TERM_CLR:
            begin
                m_we      = 1'b1;
                m_wa      = kidx_reg[SW-1:0];
                m_wd      = 1'b0;
                kidx_next = kidx_reg + CW'(1);
            end
            sab_pkg::OP_FP_MARK:
            begin
                m_we = 1'b1; m_wa = p_idx; m_wd = 1'b1;
                l_re = 1'b1; l_ra = p_idx;
            end
            sab_pkg::OP_FP_NEXT:
            begin
                p_next = link_rd;
            end
            sab_pkg::OP_REP_RD:
            begin
                t_re = 1'b1; t_ra = tidx(rep_s, c_sel);
                l_re = 1'b1; l_ra = rep_s;
                n_re = 1'b1; n_ra = rep_s;
                m_re = 1'b1; m_ra = rep_s;
            end
            sab_pkg::OP_REP_OUT:
            begin
                done_next    = 1'b1;
                o_id_next    = is_read ? qs_reg : 10'(last_reg);
                o_made_next  = 1'b0;
                o_clone_next = '0;
                o_count_next = 11'(count_reg);
                o_full_next  = 1'b0;
                if (!is_read || qs_ok)
                begin
                    o_link_next = 11'(32'(link_rd));
                    o_len_next  = 10'(len_rd);
                    o_term_next = term_rd;
                    o_tr_next   = (is_read && stat.sym_ok) ? 10'(tr_rd) : '0;
                end
                else
                begin
                    o_link_next = '0;
                    o_len_next  = '0;
                    o_term_next = 1'b0;
                    o_tr_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg     <= sab_pkg::FUNC_APPEND;
            sym_reg      <= '0;
            qs_reg       <= '0;
            last_reg     <= '0;
            last_len_reg <= '0;
            count_reg    <= CW'(1);
            v_reg        <= '0;
            lenv_reg     <= '0;
            vlink_reg    <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            lenp_reg     <= '0;
            clone_reg    <= '0;
            made_reg     <= 1'b0;
            row_reg      <= '0;
            idx_reg      <= '0;
            kidx_reg     <= '0;
            done_reg     <= 1'b0;
            o_id_reg     <= '0;
            o_link_reg   <= '0;
            o_len_reg    <= '0;
            o_tr_reg     <= '0;
            o_term_reg   <= 1'b0;
            o_made_reg   <= 1'b0;
            o_clone_reg  <= '0;
            o_count_reg  <= '0;
            o_full_reg   <= 1'b0;
        end
        else
        begin
            func_reg     <= func_next;
            sym_reg      <= sym_next;
            qs_reg       <= qs_next;
            last_reg     <= last_next;
            last_len_reg <= last_len_next;
            count_reg    <= count_next;
            v_reg        <= v_next;
            lenv_reg     <= lenv_next;
            vlink_reg    <= vlink_next;
            p_reg        <= p_next;
            q_reg        <= q_next;
            lenp_reg     <= lenp_next;
            clone_reg    <= clone_next;
            made_reg     <= made_next;
            row_reg      <= row_next;
            idx_reg      <= idx_next;
            kidx_reg     <= kidx_next;
            done_reg     <= done_next;
            o_id_reg     <= o_id_next;
            o_link_reg   <= o_link_next;
            o_len_reg    <= o_len_next;
            o_tr_reg     <= o_tr_next;
            o_term_reg   <= o_term_next;
            o_made_reg   <= o_made_next;
            o_clone_reg  <= o_clone_next;
            o_count_reg  <= o_count_next;
            o_full_reg   <= o_full_next;
        end
    end

    assign done        = done_reg;
    assign state_id    = o_id_reg;
    assign suffix_link = o_link_reg;
    assign length      = o_len_reg;
    assign transition  = o_tr_reg;
    assign is_terminal = o_term_reg;
    assign clone_made  = o_made_reg;
    assign clone_id    = o_clone_reg;
    assign state_count = o_count_reg;
    assign full_res    = o_full_reg;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for suffix_automaton_builder
// holds its own automaton predictor and checks every result; depends on sab_pkg
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [9:0]  state_id;
        logic [10:0] suffix_link;
        logic [9:0]  length;
        logic [9:0]  transition;
        logic        is_terminal;
        logic        clone_made;
        logic [9:0]  clone_id;
        logic [10:0] state_count;
        logic        full_res;
    } sam_result_t;

    localparam int NSTATES = 1024;
    localparam int NSYM    = 64;
    localparam int LEN_CAP = 512;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [5:0]  symbol;
    logic [9:0]  query_state;
    logic        done;
    logic [9:0]  state_id;
    logic signed [10:0] suffix_link;
    logic [9:0]  length;
    logic [9:0]  transition;
    logic        is_terminal;
    logic        clone_made;
    logic [9:0]  clone_id;
    logic [10:0] state_count;
    logic        full_res;

    // predictor state
    logic [9:0] goto_row [NSTATES*NSYM];
    int         link_of  [NSTATES];
    int         len_of   [NSTATES];
    bit         term_of  [NSTATES];
    int         last_st;
    int         n_states;

    sam_result_t expected_q [$];
    int          n_errors;

    suffix_automaton_builder u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .symbol(symbol), .query_state(query_state),
        .done(done), .state_id(state_id), .suffix_link(suffix_link),
        .length(length), .transition(transition), .is_terminal(is_terminal),
        .clone_made(clone_made), .clone_id(clone_id),
        .state_count(state_count), .full_res(full_res)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #300ms;
        $display("suffix_automaton_builder verification failed");
        $finish;
    end

    function automatic void model_clear_state(int s);
        for (int k = 0; k < NSYM; k++)
            goto_row[s*NSYM + k] = '0;
        link_of[s] = 0;
        len_of[s]  = 0;
        term_of[s] = 0;
    endfunction

    function automatic void model_report(int s, int c, ref sam_result_t r);
        r.state_id = s[9:0];
        if (s < n_states)
        begin
            r.suffix_link = link_of[s][10:0];
            r.length      = len_of[s][9:0];
            r.transition  = (c < NSYM) ? goto_row[s*NSYM + c] : '0;
            r.is_terminal = term_of[s];
        end
    endfunction

    function automatic sam_result_t predict_automaton(sab_pkg::func_t f, int c, int qs);
        sam_result_t r;
        int v;
        int p;
        int q;
        int cl;
        r = '0;
        case (f)
            sab_pkg::FUNC_APPEND:
            begin
                if (n_states + 2 > NSTATES || len_of[last_st] >= LEN_CAP)
                    r.full_res = 1'b1;
                else
                begin
                    v = n_states;
                    model_clear_state(v);
                    len_of[v] = len_of[last_st] + 1;
                    n_states++;
                    p = last_st;
                    while (p >= 0 && goto_row[p*NSYM + c] == 0)
                    begin
                        goto_row[p*NSYM + c] = v[9:0];
                        p = link_of[p];
                    end
                    if (p < 0)
                        link_of[v] = 0;
                    else
                    begin
                        q = goto_row[p*NSYM + c];
                        if (len_of[p] + 1 == len_of[q])
                            link_of[v] = q;
                        else
                        begin
                            cl = n_states;
                            n_states++;
                            for (int k = 0; k < NSYM; k++)
                                goto_row[cl*NSYM + k] = goto_row[q*NSYM + k];
                            len_of[cl]  = len_of[p] + 1;
                            link_of[cl] = link_of[q];
                            term_of[cl] = 0;
                            link_of[v]  = cl;
                            link_of[q]  = cl;
                            while (p >= 0 && goto_row[p*NSYM + c] == q)
                            begin
                                goto_row[p*NSYM + c] = cl[9:0];
                                p = link_of[p];
                            end
                            r.clone_made = 1'b1;
                            r.clone_id   = cl[9:0];
                        end
                    end
                    last_st     = v;
                    r.state_id    = v[9:0];
                    r.suffix_link = link_of[v][10:0];
                    r.length      = len_of[v][9:0];
                end
            end
            sab_pkg::FUNC_FINISH:
            begin
                for (int s = 0; s < NSTATES; s++)
                    term_of[s] = 0;
                p = last_st;
                while (p > 0)
                begin
                    term_of[p] = 1;
                    p = link_of[p];
                end
                model_report(last_st, NSYM, r);
            end
            sab_pkg::FUNC_CLEAR:
            begin
                model_clear_state(0);
                link_of[0] = -1;
                last_st    = 0;
                n_states   = 1;
                model_report(last_st, NSYM, r);
            end
            default:
                model_report(qs, c, r);
        endcase
        r.state_count = n_states[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int exp);
        $display("mismatch on %s at %0t: got %0d expected %0d", field, $time, got, exp);
        n_errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        sam_result_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_q.pop_front();
                if (state_id !== e.state_id)
                    report_mismatch("state_id", state_id, e.state_id);
                if (suffix_link !== e.suffix_link)
                    report_mismatch("suffix_link", suffix_link, $signed(e.suffix_link));
                if (length !== e.length)
                    report_mismatch("length", length, e.length);
                if (transition !== e.transition)
                    report_mismatch("transition", transition, e.transition);
                if (is_terminal !== e.is_terminal)
                    report_mismatch("is_terminal", is_terminal, e.is_terminal);
                if (clone_made !== e.clone_made)
                    report_mismatch("clone_made", clone_made, e.clone_made);
                if (clone_id !== e.clone_id)
                    report_mismatch("clone_id", clone_id, e.clone_id);
                if (state_count !== e.state_count)
                    report_mismatch("state_count", state_count, e.state_count);
                if (full_res !== e.full_res)
                    report_mismatch("full_res", full_res, e.full_res);
            end
        end
    end

    // one command transfer, with a random hold-off before it
    task automatic send_command(sab_pkg::func_t f, int c, int qs);
        int gap;
        gap = $urandom_range(5);
        if ($urandom_range(3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        symbol      <= c[5:0];
        query_state <= qs[9:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_q.insert(expected_q.size(), predict_automaton(f, c, qs));
    endtask

    task automatic test_directed;
        send_command(sab_pkg::FUNC_READ, 0, 0);
        send_command(sab_pkg::FUNC_READ, 63, 1023);
        send_command(sab_pkg::FUNC_FINISH, 0, 0);
        send_command(sab_pkg::FUNC_APPEND, 0, 0);
        send_command(sab_pkg::FUNC_APPEND, 63, 0);
        send_command(sab_pkg::FUNC_APPEND, 63, 0);
        send_command(sab_pkg::FUNC_APPEND, 0, 0);
        send_command(sab_pkg::FUNC_APPEND, 63, 0);
        send_command(sab_pkg::FUNC_READ, 63, 0);
        send_command(sab_pkg::FUNC_READ, 0, 2);
        send_command(sab_pkg::FUNC_READ, 21, 3);
        send_command(sab_pkg::FUNC_READ, 42, 1000);
        send_command(sab_pkg::FUNC_FINISH, 0, 0);
        send_command(sab_pkg::FUNC_READ, 0, 4);
        send_command(sab_pkg::FUNC_FINISH, 0, 0);
        send_command(sab_pkg::FUNC_CLEAR, 0, 0);
        send_command(sab_pkg::FUNC_READ, 0, 3);
        send_command(sab_pkg::FUNC_READ, 0, 0);
    endtask

    task automatic test_length_limit;
        send_command(sab_pkg::FUNC_CLEAR, 0, 0);
        for (int i = 0; i < LEN_CAP + 2; i++)
            send_command(sab_pkg::FUNC_APPEND, 5, 0);
        send_command(sab_pkg::FUNC_READ, 5, 511);
        send_command(sab_pkg::FUNC_FINISH, 0, 0);
    endtask

    task automatic test_state_limit;
        send_command(sab_pkg::FUNC_CLEAR, 0, 0);
        send_command(sab_pkg::FUNC_APPEND, 1, 0);
        for (int i = 0; i < LEN_CAP + 2; i++)
            send_command(sab_pkg::FUNC_APPEND, 2, 0);
        send_command(sab_pkg::FUNC_READ, 2, 1022);
        send_command(sab_pkg::FUNC_READ, 1, 1023);
        send_command(sab_pkg::FUNC_CLEAR, 0, 0);
    endtask

    task automatic test_random;
        int alpha;
        int seg;
        int pick;
        int qs;
        for (int i = 0; i < 150; i++)
        begin
            if (seg == 0)
            begin
                seg = $urandom_range(20, 120);
                case ($urandom_range(3))
                    0: alpha = 2;
                    1: alpha = 3;
                    2: alpha = 5;
                    default: alpha = NSYM;
                endcase
                send_command(sab_pkg::FUNC_CLEAR, $urandom_range(63), $urandom_range(1023));
            end
            seg--;
            pick = $urandom_range(99);
            if (pick < 65)
                send_command(sab_pkg::FUNC_APPEND, $urandom_range(alpha - 1),
                             $urandom_range(1023));
            else if (pick < 93)
            begin
                qs = ($urandom_range(4) == 0) ? $urandom_range(1023)
                                              : $urandom_range(n_states - 1);
                send_command(sab_pkg::FUNC_READ, $urandom_range(63), qs);
            end
            else
                send_command(sab_pkg::FUNC_FINISH, $urandom_range(63), $urandom_range(1023));
        end
    endtask

    initial
    begin
        start       = 1'b0;
        func        = '0;
        symbol      = '0;
        query_state = '0;
        rst_n       = 1'b0;
        n_errors    = 0;
        for (int s = 0; s < NSTATES; s++)
            model_clear_state(s);
        link_of[0] = -1;
        last_st    = 0;
        n_states   = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_length_limit();
        test_state_limit();
        test_random();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (n_errors == 0)
            $display("suffix_automaton_builder verification clean");
        else
            $display("suffix_automaton_builder verification failed");
        $finish;
    end
endmodule
